>>> sv/grey_convert_and_brim_detect_macros.svh
// Assertion macros shared by gcbd_scan and the top-level RTL file.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef GREY_CONVERT_AND_BRIM_DETECT_MACROS_SVH
`define GREY_CONVERT_AND_BRIM_DETECT_MACROS_SVH

// Check cons in the same cycle whenever ante holds.
`define GCBD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante holds.
`define GCBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/gcbd_pkg.sv
package gcbd_pkg;

  // Register indexes on the write port
  typedef enum logic [1:0] {
    REG_LINE_WIDTH   = 2'd0,
    REG_DETECT_ROW   = 2'd1,
    REG_SEARCH_LIMIT = 2'd2,
    REG_RUN_LENGTH   = 2'd3
  } reg_index_t;

  localparam logic [11:0] LINE_WIDTH_RST   = 12'd640;
  localparam logic [11:0] DETECT_ROW_RST   = 12'd40;
  localparam logic [11:0] SEARCH_LIMIT_RST = 12'd300;
  localparam logic [3:0]  RUN_LENGTH_RST   = 4'd5;

  // Grey weights and rounding offset
  localparam logic [4:0] W_RED   = 5'd30;
  localparam logic [5:0] W_GREEN = 6'd59;
  localparam logic [3:0] W_BLUE  = 4'd11;
  localparam logic [5:0] GREY_ROUND = 6'd50;

  // x / 100 for x < 25600 as (x * 5243) >> 19
  localparam logic [12:0] GREY_RECIP = 13'd5243;
  localparam int unsigned GREY_SHIFT = 19;

  // x / 3 for x < 768 as (x * 683) >> 11
  localparam logic [9:0]  MEAN_RECIP = 10'd683;
  localparam int unsigned MEAN_SHIFT = 11;

  localparam logic [11:0] ROW_MAX = 12'd4095;
  localparam logic [3:0]  RUN_MAX = 4'd15;

  typedef struct packed {
    logic [11:0] line_width;
    logic [11:0] detect_row;
    logic [11:0] search_limit;
    logic [3:0]  run_length;
  } cfg_t;

  typedef struct packed {
    logic        found;
    logic [11:0] column;
    logic        failed;
  } scan_res_t;

endpackage

>>> sv/gcbd_if.sv
interface gcbd_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       frame_start;

  modport source (output valid, red, green, blue, frame_start, input ready);
  modport sink (input valid, red, green, blue, frame_start, output ready);
endinterface

interface gcbd_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  grey;
  logic        brim_found;
  logic [11:0] brim_column;
  logic        search_failed;

  modport source (output valid, grey, brim_found, brim_column, search_failed, input ready);
  modport sink (input valid, grey, brim_found, brim_column, search_failed, output ready);
endinterface

>>> sv/gcbd_grey.sv
module gcbd_grey (
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic       frame_start,
  output logic [7:0] grey,
  output logic       grey_frame_start
);
  import gcbd_pkg::*;

  logic [14:0] wsum;
  logic [27:0] prod;

  // 30R + 59G + 11B + 50 stays below 25600
  always_comb begin
    wsum = 15'(red * W_RED) + 15'(green * W_GREEN) + 15'(blue * W_BLUE) + 15'(GREY_ROUND);
    prod = 28'(wsum) * 28'(GREY_RECIP);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grey             <= prod[GREY_SHIFT +: 8];
      grey_frame_start <= frame_start;
    end
  end

endmodule

>>> sv/gcbd_scan.sv
`include "grey_convert_and_brim_detect_macros.svh"

module gcbd_scan (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic [7:0]        grey,
  input  logic              frame_start,
  input  gcbd_pkg::cfg_t    cfg,
  output gcbd_pkg::scan_res_t res
);
  import gcbd_pkg::*;

  logic [11:0] column_count, row_count;
  logic [7:0]  recent0, recent1;
  logic [7:0]  previous_mean;
  logic [3:0]  decrease_run;
  logic        search_done;

  logic [11:0] col_e, row_e, idx;
  logic [7:0]  prev_e, mean;
  logic [3:0]  run_e;
  logic        done_e, eor, active;
  logic [9:0]  mean_sum;
  logic [19:0] mean_prod;

  logic [11:0] column_count_next, row_count_next;
  logic [7:0]  previous_mean_next;
  logic [3:0]  decrease_run_next;
  logic        search_done_next;

  always_comb begin
    // frame start clears position and search before this pixel
    col_e  = frame_start ? '0 : column_count;
    row_e  = frame_start ? '0 : row_count;
    prev_e = frame_start ? '0 : previous_mean;
    run_e  = frame_start ? '0 : decrease_run;
    done_e = frame_start ? 1'b0 : search_done;

    eor    = (13'(col_e) + 13'd1) >= 13'(cfg.line_width);
    active = (row_e == cfg.detect_row) && !done_e;
    idx    = col_e - 12'd2;

    mean_sum  = 10'(recent1) + 10'(recent0) + 10'(grey);
    mean_prod = 20'(mean_sum) * 20'(MEAN_RECIP);
    mean      = mean_prod[MEAN_SHIFT +: 8];

    res                = '0;
    previous_mean_next = prev_e;
    decrease_run_next  = run_e;

    if (active && col_e >= 12'd2) begin
      if (idx >= cfg.search_limit) begin
        res.failed = 1'b1;
      end else begin
        if (idx == '0 || mean >= prev_e) begin
          decrease_run_next = '0;
        end else if (run_e < RUN_MAX) begin
          decrease_run_next = run_e + 4'd1;
        end
        previous_mean_next = mean;
        if (decrease_run_next >= cfg.run_length) begin
          res.found  = 1'b1;
          res.column = idx;
        end else if ((13'(idx) + 13'd1) >= 13'(cfg.search_limit)) begin
          res.failed = 1'b1;
        end
      end
    end
    // row ran out before the search finished
    if (active && !res.found && !res.failed && eor) begin
      res.failed = 1'b1;
    end
    search_done_next = done_e | (active & (res.found | res.failed));

    if (eor) begin
      column_count_next = '0;
      row_count_next    = (row_e < ROW_MAX) ? row_e + 12'd1 : row_e;
    end else begin
      column_count_next = col_e + 12'd1;
      row_count_next    = row_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      recent0       <= '0;
      recent1       <= '0;
      previous_mean <= '0;
      decrease_run  <= '0;
      search_done   <= 1'b0;
    end else if (adv) begin
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      recent1       <= recent0;
      recent0       <= grey;
      previous_mean <= previous_mean_next;
      decrease_run  <= decrease_run_next;
      search_done   <= search_done_next;
    end
  end

  `GCBD_ASSERT_SAME(a_single_report, adv && search_done && !frame_start, !res.found && !res.failed, "second report in one frame")
  `GCBD_ASSERT_SAME(a_column_in_limit, adv && res.found, res.column < cfg.search_limit, "brim column beyond search limit")
  `GCBD_ASSERT_NEXT(a_row_step, adv && !frame_start && eor && row_count < ROW_MAX, row_count == $past(row_count) + 12'd1, "row count missed a row end")

endmodule

>>> sv/grey_convert_and_brim_detect.sv
// Grey conversion with left-brim scan.
// pixel (sink): one RGB word per pixel in raster order; frame_start marks the
//   first pixel of a frame and restarts position and search.
// result (source): one word per pixel: grey = (30R+59G+11B+50)/100, plus
//   brim_found / brim_column and search_failed, each raised at most once per
//   frame on the pixel that decides the scan of the detect row.
// wr_en / wr_index / wr_data: register writes (line width, detect row, search
//   limit, run length); write only while no pixel is in flight.
// Throughput: one pixel per cycle unless a result waits with result.ready low, set by a
//   three-register pipeline (input, grey, result) that advances together.
// Path: a taken pixel passes the input, grey and result registers in that order.
// Reset: synchronous; empties the pipeline, loads register defaults and clears
//   position, history and search state as at a frame start.
// Stall: while a result waits with result.ready low the whole pipeline holds
//   and pixel.ready drops; pixel.ready follows result.ready combinationally.
`include "grey_convert_and_brim_detect_macros.svh"

module grey_convert_and_brim_detect (
  input  logic        clk,
  input  logic        rst,
  gcbd_pix_if.sink    pixel,
  gcbd_res_if.source  result,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [11:0] wr_data
);
  import gcbd_pkg::*;

  cfg_t        cfg;
  logic        stall;
  logic        s1_valid, s2_valid, out_valid;
  logic [7:0]  s1_red, s1_green, s1_blue;
  logic        s1_fs;
  logic [7:0]  s2_grey;
  logic        s2_fs;
  logic        scan_adv;
  scan_res_t   scan_res;
  logic [7:0]  out_grey;
  scan_res_t   out_res;

  // Hold every stage while the result register is full and not taken
  assign stall       = out_valid && !result.ready;
  assign pixel.ready = !stall;
  assign scan_adv    = !stall && s2_valid;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_width   <= LINE_WIDTH_RST;
      cfg.detect_row   <= DETECT_ROW_RST;
      cfg.search_limit <= SEARCH_LIMIT_RST;
      cfg.run_length   <= RUN_LENGTH_RST;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_LINE_WIDTH:   cfg.line_width   <= wr_data;
        REG_DETECT_ROW:   cfg.detect_row   <= wr_data;
        REG_SEARCH_LIMIT: cfg.search_limit <= wr_data;
        REG_RUN_LENGTH:   cfg.run_length   <= wr_data[3:0];
        default: ;
      endcase
    end
  end

  // Valid bits advance together
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (!stall) begin
      s1_valid  <= pixel.valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!stall && pixel.valid) begin
      s1_red   <= pixel.red;
      s1_green <= pixel.green;
      s1_blue  <= pixel.blue;
      s1_fs    <= pixel.frame_start;
    end
  end

  gcbd_grey u_grey (
    .clk              (clk),
    .en               (!stall && s1_valid),
    .red              (s1_red),
    .green            (s1_green),
    .blue             (s1_blue),
    .frame_start      (s1_fs),
    .grey             (s2_grey),
    .grey_frame_start (s2_fs)
  );

  gcbd_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .adv         (scan_adv),
    .grey        (s2_grey),
    .frame_start (s2_fs),
    .cfg         (cfg),
    .res         (scan_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (scan_adv) begin
      out_grey <= s2_grey;
      out_res  <= scan_res;
    end
  end

  assign result.valid         = out_valid;
  assign result.grey          = out_grey;
  assign result.brim_found    = out_res.found;
  assign result.brim_column   = out_res.column;
  assign result.search_failed = out_res.failed;

  `GCBD_ASSERT_SAME(a_found_xor_failed, result.valid, !(result.brim_found && result.search_failed), "found and failed on one word")
  `GCBD_ASSERT_SAME(a_column_zero, result.valid && !result.brim_found, result.brim_column == 12'd0, "brim column set without a find")
  `GCBD_ASSERT_SAME(a_result_source, $rose(out_valid), $past(s2_valid), "result appeared without a grey stage word")

endmodule
